// File: hw/rtl/ntgc_pkg.sv
// ntgc_pkg: shared widths, codes, constants and the arctangent table of the
// nearest-target go-to-goal controller. Used by the multiplier and the top level.
// No dependencies.
`default_nettype none
package ntgc_pkg;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 35;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // default number of vectoring iterations
  localparam int unsigned NTGC_CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN          = 24;

  // input operation codes
  typedef enum logic [1:0] {
    OP_POSE      = 2'd0,
    OP_CANDIDATE = 2'd1,
    OP_TICK      = 2'd2,
    OP_EMPTY     = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_LINEAR_GAIN  = 2'd0;
  localparam logic [1:0] REG_ANGULAR_GAIN = 2'd1;
  localparam logic [1:0] REG_CATCH_RADIUS = 2'd2;

  localparam logic [15:0] LINEAR_GAIN_RST  = 16'd512;
  localparam logic [15:0] ANGULAR_GAIN_RST = 16'd1536;
  localparam logic [15:0] CATCH_RADIUS_RST = 16'd128;

  // cordic gain inverse in Q30, split into two 15-bit halves
  localparam longint unsigned GAIN_INV = 64'd652032874;
  localparam logic [14:0] GAIN_INV_LO = 15'(GAIN_INV % 32768);
  localparam logic [14:0] GAIN_INV_HI = 15'(GAIN_INV / 32768);

  // binary angle to Q3.12 radians factor, split into two 14-bit halves
  localparam longint unsigned RAD_CONV = 64'd105414357;
  localparam logic [13:0] RAD_CONV_LO = 14'(RAD_CONV % 16384);
  localparam logic [13:0] RAD_CONV_HI = 14'(RAD_CONV / 16384);

  localparam logic signed [18:0] PI_Q12     = 19'sd12868;
  localparam logic signed [18:0] TWO_PI_Q12 = 19'sd25736;

  // arctangent of 2^-i as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ntgc_mul.sv
// ntgc_mul: shared signed multiplier with a registered product.
// Depends on ntgc_pkg for operand widths.
`default_nettype none
module ntgc_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [ntgc_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [ntgc_pkg::MUL_B_W-1:0] b,
  output logic signed      [ntgc_pkg::MUL_P_W-1:0] p
);

  // product register, held while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/nearest_target_go_to_goal_controller_unit.sv
// Go-to-goal proportional controller with nearest-target selection, the top level.
// Depends on ntgc_pkg and ntgc_mul.
//
// One request at a time. A pose or empty-list request is done in the accept cycle. A
// candidate passes through S_SQX, S_SQY and S_CMP: two squares and a compare through the
// one shared multiplier. A control tick with pose and goal valid runs as follows: the
// accept cycle does the pre-rotation, then one vectoring iteration per cycle in the
// shared shift-add unit, then the states S_D1 to S_ANG pass six products through the
// shared 35x18 multiplier for distance, bearing and the two speeds, and S_OUT loads the
// result register. The result register sits between the two sides; a tick finishing
// while an earlier result is still not taken waits for it. A tick without pose or goal
// gives no result.
`default_nettype none
module nearest_target_go_to_goal_controller_unit #(
  parameter int unsigned CORDIC_STEPS = ntgc_pkg::NTGC_CORDIC_STEPS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // candidate, pose, tick and empty-list requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x[15:0], pos_y[31:16], heading[46:32], target_id[54:47], zero[55]
  input  wire logic [55:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  // speed commands
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // linear_speed[23:0], angular_speed[47:24], caught_id[55:48]
  output logic [55:0]      m_axis_tdata,
  // caught[0]
  output logic             m_axis_tuser,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);
  localparam int unsigned AW = ntgc_pkg::MUL_A_W;
  localparam int unsigned BW = ntgc_pkg::MUL_B_W;
  localparam int unsigned PW = ntgc_pkg::MUL_P_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_CMP, S_ROT, S_D1, S_D2, S_D3, S_B1, S_B2,
    S_LIN, S_ANG, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [15:0] linear_gain, angular_gain, catch_radius;

  // stored pose, goal and search
  logic signed [15:0] own_x, own_y, goal_x, goal_y, best_x, best_y;
  logic signed [14:0] own_heading;
  logic [7:0]         goal_id, best_id;
  logic               pose_valid, goal_valid;
  logic [33:0]        best_square_distance;

  // candidate under work
  logic signed [15:0] cand_x, cand_y;
  logic [7:0]         cand_id;
  logic               cand_last;

  // datapath registers
  logic signed [16:0] dx, dy;
  logic signed [27:0] cx, cy;
  logic signed [33:0] cang;
  logic [STEP_W-1:0]  step;
  logic               zero_vec;
  logic [61:0]        acc;
  logic [19:0]        distance;
  logic signed [18:0] err;
  logic               caught_r;
  logic [23:0]        lin;

  // multiplier
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic                 mul_en;

  // request fields
  logic signed [15:0] in_x, in_y;
  logic signed [14:0] in_heading;
  logic [7:0]         in_id;
  logic signed [16:0] in_dx, in_dy, tdx, tdy;
  logic signed [27:0] sx, sy, xs, ys;
  logic [31:0]        atan_v;
  logic [27:0]        xclamp;
  logic [33:0]        mag;
  logic [33:0]        sq;
  logic [61:0]        dist_sum, brg_sum;
  logic [16:0]        q;
  logic signed [18:0] bearing, err_raw;
  logic [PW-1:0]      lin_sum;
  logic signed [PW-1:0] ang_sum;
  logic signed [PW-9:0] ang_sh;
  logic [23:0]        ang_sat;
  logic               in_fire, out_free;

  assign in_x       = s_axis_tdata[15:0];
  assign in_y       = s_axis_tdata[31:16];
  assign in_heading = s_axis_tdata[46:32];
  assign in_id      = s_axis_tdata[54:47];
  assign in_dx      = 17'(in_x) - 17'(own_x);
  assign in_dy      = 17'(in_y) - 17'(own_y);
  assign tdx        = 17'(goal_x) - 17'(own_x);
  assign tdy        = 17'(goal_y) - 17'(own_y);
  assign sx         = {{3{tdx[16]}}, tdx, 8'b0};
  assign sy         = {{3{tdy[16]}}, tdy, 8'b0};

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // shift-add unit of one vectoring iteration
  assign xs     = cx >>> step;
  assign ys     = cy >>> step;
  assign atan_v = ntgc_pkg::atan_entry(5'(step));

  // distance and bearing rounding
  assign xclamp   = cx[27] ? 28'd0 : cx;
  assign mag      = cang[33] ? 34'(-cang) : 34'(cang);
  assign sq       = 34'(acc) + 34'(mul_p);
  assign dist_sum = acc + {mul_p[46:0], 15'b0} + (62'd1 << 37);
  assign brg_sum  = acc + {mul_p[47:0], 14'b0} + (62'd1 << 43);
  assign q        = brg_sum[60:44];
  assign bearing  = zero_vec ? 19'sd0 : (cang[33] ? -19'($signed({2'b0, q}))
                                                  : 19'($signed({2'b0, q})));
  assign err_raw  = bearing - 19'(own_heading);

  // speed rounding
  assign lin_sum = mul_p + PW'(128);
  assign ang_sum = mul_p + PW'(128);
  assign ang_sh  = ang_sum[PW-1:8];

  always_comb begin
    if (ang_sh > (PW-8)'(8388607)) begin
      ang_sat = 24'h7FFFFF;
    end else if (ang_sh < -(PW-8)'(8388608)) begin
      ang_sat = 24'h800000;
    end else begin
      ang_sat = ang_sh[23:0];
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX: begin
        mul_a = AW'(dx);
        mul_b = BW'(dx);
      end
      S_SQY: begin
        mul_a = AW'(dy);
        mul_b = BW'(dy);
      end
      S_D1: begin
        mul_a = AW'(xclamp);
        mul_b = BW'(ntgc_pkg::GAIN_INV_LO);
      end
      S_D2: begin
        mul_a = AW'(xclamp);
        mul_b = BW'(ntgc_pkg::GAIN_INV_HI);
      end
      S_D3: begin
        mul_a = AW'(mag);
        mul_b = BW'(ntgc_pkg::RAD_CONV_LO);
      end
      S_B1: begin
        mul_a = AW'(mag);
        mul_b = BW'(ntgc_pkg::RAD_CONV_HI);
      end
      S_LIN: begin
        mul_a = AW'(distance);
        mul_b = BW'(linear_gain);
      end
      S_ANG: begin
        mul_a = AW'(err);
        mul_b = BW'(angular_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_en = (state != S_OUT);

  ntgc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain  <= ntgc_pkg::LINEAR_GAIN_RST;
      angular_gain <= ntgc_pkg::ANGULAR_GAIN_RST;
      catch_radius <= ntgc_pkg::CATCH_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ntgc_pkg::REG_LINEAR_GAIN:  linear_gain  <= cfg_data;
        ntgc_pkg::REG_ANGULAR_GAIN: angular_gain <= cfg_data;
        ntgc_pkg::REG_CATCH_RADIUS: catch_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, stored state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      own_x                <= '0;
      own_y                <= '0;
      own_heading          <= '0;
      pose_valid           <= 1'b0;
      goal_x               <= '0;
      goal_y               <= '0;
      goal_id              <= '0;
      goal_valid           <= 1'b0;
      best_x               <= '0;
      best_y               <= '0;
      best_id              <= '0;
      best_square_distance <= '1;
      m_axis_tvalid        <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (ntgc_pkg::op_t'(s_axis_tuser))
              ntgc_pkg::OP_POSE: begin
                own_x       <= in_x;
                own_y       <= in_y;
                own_heading <= in_heading;
                pose_valid  <= 1'b1;
              end
              ntgc_pkg::OP_CANDIDATE: begin
                dx        <= in_dx;
                dy        <= in_dy;
                cand_x    <= in_x;
                cand_y    <= in_y;
                cand_id   <= in_id;
                cand_last <= s_axis_tlast;
                state     <= S_SQX;
              end
              ntgc_pkg::OP_TICK: begin
                if (pose_valid && goal_valid) begin
                  zero_vec <= (tdx == 17'sd0) && (tdy == 17'sd0);
                  step     <= '0;
                  // quarter turn into the right half plane
                  if (!sx[27]) begin
                    cx   <= sx;
                    cy   <= sy;
                    cang <= '0;
                  end else if (!sy[27]) begin
                    cx   <= sy;
                    cy   <= -sx;
                    cang <= 34'sh040000000;
                  end else begin
                    cx   <= -sy;
                    cy   <= sx;
                    cang <= -34'sh040000000;
                  end
                  state <= S_ROT;
                end
              end
              ntgc_pkg::OP_EMPTY: begin
                goal_valid           <= 1'b0;
                best_square_distance <= '1;
              end
              default: ;
            endcase
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= 62'(mul_p);
          state <= S_CMP;
        end
        S_CMP: begin
          // strict less keeps the earlier candidate on ties
          if (sq < best_square_distance) begin
            best_x  <= cand_x;
            best_y  <= cand_y;
            best_id <= cand_id;
          end
          if (cand_last) begin
            if (sq < best_square_distance) begin
              goal_x  <= cand_x;
              goal_y  <= cand_y;
              goal_id <= cand_id;
            end else begin
              goal_x  <= best_x;
              goal_y  <= best_y;
              goal_id <= best_id;
            end
            goal_valid           <= 1'b1;
            best_square_distance <= '1;
          end else if (sq < best_square_distance) begin
            best_square_distance <= sq;
          end
          state <= S_IDLE;
        end
        S_ROT: begin
          if (!cy[27]) begin
            cx   <= cx + ys;
            cy   <= cy - xs;
            cang <= cang + 34'(atan_v);
          end else begin
            cx   <= cx - ys;
            cy   <= cy + xs;
            cang <= cang - 34'(atan_v);
          end
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_D1;
          end
        end
        S_D1: state <= S_D2;
        S_D2: begin
          acc   <= 62'(mul_p);
          state <= S_D3;
        end
        S_D3: begin
          distance <= dist_sum[57:38];
          state    <= S_B1;
        end
        S_B1: begin
          acc   <= 62'(mul_p);
          state <= S_B2;
        end
        S_B2: begin
          // wrap the heading error once into plus or minus pi
          if (err_raw > ntgc_pkg::PI_Q12) begin
            err <= err_raw - ntgc_pkg::TWO_PI_Q12;
          end else if (err_raw < -ntgc_pkg::PI_Q12) begin
            err <= err_raw + ntgc_pkg::TWO_PI_Q12;
          end else begin
            err <= err_raw;
          end
          caught_r <= (distance < 20'(catch_radius));
          state    <= S_LIN;
        end
        S_LIN: state <= S_ANG;
        S_ANG: begin
          lin   <= (lin_sum[PW-1:32] != '0) ? 24'hFFFFFF : lin_sum[31:8];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= caught_r;
            if (caught_r) begin
              m_axis_tdata <= {goal_id, 48'd0};
            end else begin
              m_axis_tdata <= {8'd0, ang_sat, lin};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a caught result carries zero speeds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[47:0] == 48'd0))
    else $error("caught result with nonzero speed");

  // a result that is not caught carries no identity
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[55:48] == 8'd0))
    else $error("identity on a result that is not caught");

  // a tick without pose or goal leaves the block ready
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_axis_tuser == ntgc_pkg::OP_TICK) && !(pose_valid && goal_valid))
    |=> s_axis_tready)
    else $error("tick without pose or goal started work");

  // a result is only loaded from the final state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_OUT))
    else $error("result appeared outside the output step");

endmodule
`default_nettype wire
